>>> src/frp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frp_pkg
// Shared types and character constants for the FASTA record parser.
// ----------------------------------------------------------------------------
package frp_pkg;

    // Character codes
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_VT    = 8'h0B;
    localparam logic [7:0] C_FF    = 8'h0C;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_DASH  = 8'h2D;
    localparam logic [7:0] C_DOT   = 8'h2E;
    localparam logic [7:0] C_GT    = 8'h3E;
    localparam logic [7:0] C_UC_A  = 8'h41;
    localparam logic [7:0] C_UC_Z  = 8'h5A;
    localparam logic [7:0] C_LC_A  = 8'h61;
    localparam logic [7:0] C_LC_Z  = 8'h7A;

    // Input item kinds
    localparam logic IN_DATA = 1'b0;
    localparam logic IN_END  = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_BITS = 2;
    localparam int unsigned CFG_DATA_BITS = 24;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ALLOW_GAPS = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRUNCATE   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_LENGTH = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_LENGTH = 2'd3;

    // Parser modes
    typedef enum logic [2:0] {
        M_FIRST = 3'd0,
        M_LABEL = 3'd1,
        M_SKIP  = 3'd2,
        M_SEQ   = 3'd3,
        M_ERROR = 3'd4
    } t_mode;

    // Result kinds
    typedef enum logic [1:0] {
        OK_LABEL = 2'd0,
        OK_SEQ   = 2'd1,
        OK_END   = 2'd2,
        OK_ERROR = 2'd3
    } t_out_kind;

    // Record verdicts
    typedef enum logic [1:0] {
        V_KEPT  = 2'd0,
        V_SHORT = 2'd1,
        V_LONG  = 2'd2
    } t_verdict;

    // Byte classes
    typedef struct packed {
        logic is_eol;
        logic is_letter;
        logic is_gap;
        logic is_hdr;
        logic is_ws;
        logic is_tab;
    } t_byte_class;

    // Result request from the parser control
    typedef struct packed {
        logic      valid;
        logic      close;
        t_out_kind kind;
        logic [7:0] data;
    } t_ctrl_res;

    // Record statistics as seen on the result
    typedef struct packed {
        t_verdict    verdict;
        logic [31:0] index;
        logic [31:0] short_count;
        logic [31:0] long_count;
        logic [23:0] shortest;
        logic [23:0] longest;
    } t_stats_view;

endpackage : frp_pkg
`default_nettype wire

>>> src/frp_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frp_in_if
// Input byte channel: valid/ready handshake with kind and data byte.
// ----------------------------------------------------------------------------
interface frp_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface : frp_in_if
`default_nettype wire

>>> src/frp_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frp_out_if
// Result channel: valid/ready handshake with the parser result fields.
// ----------------------------------------------------------------------------
interface frp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic [23:0] record_length;
    logic [1:0]  verdict;
    logic [31:0] record_index;
    logic        bad_byte_seen;
    logic [31:0] short_count;
    logic [31:0] long_count;
    logic [23:0] shortest_discarded;
    logic [23:0] longest_discarded;

    modport source (
        output valid, output out_kind, output out_byte, output record_length,
        output verdict, output record_index, output bad_byte_seen,
        output short_count, output long_count, output shortest_discarded,
        output longest_discarded, input ready
    );
    modport sink (
        input valid, input out_kind, input out_byte, input record_length,
        input verdict, input record_index, input bad_byte_seen,
        input short_count, input long_count, input shortest_discarded,
        input longest_discarded, output ready
    );
endinterface : frp_out_if
`default_nettype wire

>>> src/frp_classify.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frp_classify
// Sorts one byte into line end, letter, gap, header mark, whitespace and tab.
// ----------------------------------------------------------------------------
module frp_classify (
    input  wire logic [7:0]          i_byte,
    output frp_pkg::t_byte_class     o_class
);
    import frp_pkg::*;

    always_comb begin
        o_class.is_eol    = (i_byte == C_LF) || (i_byte == C_CR);
        o_class.is_letter = ((i_byte >= C_UC_A) && (i_byte <= C_UC_Z)) ||
                            ((i_byte >= C_LC_A) && (i_byte <= C_LC_Z));
        o_class.is_gap    = (i_byte == C_DASH) || (i_byte == C_DOT);
        o_class.is_hdr    = (i_byte == C_GT);
        o_class.is_ws     = (i_byte == C_SPACE) || (i_byte == C_TAB) ||
                            (i_byte == C_VT) || (i_byte == C_FF);
        o_class.is_tab    = (i_byte == C_TAB);
    end

endmodule : frp_classify
`default_nettype wire

>>> src/frp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frp_ctrl
// Parser state machine: mode, line-start flag, letter count and the sticky
// invalid-byte flag. Decides for each accepted item what result it causes.
// ----------------------------------------------------------------------------
module frp_ctrl #(
    parameter int unsigned LENGTH_BITS = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_fire,
    input  wire logic                   i_kind,
    input  wire logic [7:0]             i_byte,
    input  wire logic                   i_allow_gaps,
    input  wire logic                   i_truncate,
    output frp_pkg::t_ctrl_res          o_res,
    output logic [LENGTH_BITS-1:0]      o_length,
    output logic                        o_bad
);
    import frp_pkg::*;

    localparam logic [LENGTH_BITS-1:0] LEN_ONE = {{(LENGTH_BITS-1){1'b0}}, 1'b1};

    t_mode                  r_mode, n_mode;
    logic                   r_prev_eol, n_prev_eol;
    logic [LENGTH_BITS-1:0] r_count, n_count;
    logic                   r_bad, n_bad;
    t_byte_class            w_class;

    frp_classify u_classify (
        .i_byte  (i_byte),
        .o_class (w_class)
    );

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_FIRST;
            r_prev_eol <= 1'b1;
            r_count    <= '0;
            r_bad      <= 1'b0;
        end else begin
            r_mode     <= n_mode;
            r_prev_eol <= n_prev_eol;
            r_count    <= n_count;
            r_bad      <= n_bad;
        end
    end

    // Next state and result request
    always_comb begin
        n_mode       = r_mode;
        n_prev_eol   = r_prev_eol;
        n_count      = r_count;
        n_bad        = r_bad;
        o_res.valid  = 1'b0;
        o_res.close  = 1'b0;
        o_res.kind   = OK_LABEL;
        o_res.data   = '0;

        if (i_fire) begin
            if (r_mode == M_ERROR) begin
                o_res.valid = 1'b1;
                o_res.kind  = OK_ERROR;
            end else if (i_kind == IN_END) begin
                // end of input closes an open record
                if (r_mode != M_FIRST) begin
                    o_res.valid = 1'b1;
                    o_res.close = 1'b1;
                    o_res.kind  = OK_END;
                    n_mode      = M_FIRST;
                    n_prev_eol  = 1'b1;
                    n_count     = '0;
                end
            end else begin
                unique case (r_mode)
                    M_FIRST: begin
                        if (w_class.is_hdr) begin
                            n_mode  = M_LABEL;
                            n_count = '0;
                        end else begin
                            n_mode      = M_ERROR;
                            o_res.valid = 1'b1;
                            o_res.kind  = OK_ERROR;
                        end
                    end
                    M_LABEL: begin
                        if (w_class.is_eol) begin
                            n_mode     = M_SEQ;
                            n_prev_eol = 1'b1;
                        end else if (i_truncate && w_class.is_ws) begin
                            n_mode = M_SKIP;
                        end else begin
                            o_res.valid = 1'b1;
                            o_res.kind  = OK_LABEL;
                            o_res.data  = (!i_truncate && w_class.is_tab) ? C_SPACE : i_byte;
                        end
                    end
                    M_SKIP: begin
                        if (w_class.is_eol) begin
                            n_mode     = M_SEQ;
                            n_prev_eol = 1'b1;
                        end
                    end
                    M_SEQ: begin
                        if (w_class.is_hdr && r_prev_eol) begin
                            // header mark at line start: close and open next
                            o_res.valid = 1'b1;
                            o_res.close = 1'b1;
                            o_res.kind  = OK_END;
                            n_mode      = M_LABEL;
                            n_prev_eol  = 1'b0;
                            n_count     = '0;
                        end else begin
                            n_prev_eol = w_class.is_eol;
                            if (w_class.is_letter || (w_class.is_gap && i_allow_gaps)) begin
                                if (r_count != '1) begin
                                    n_count = r_count + LEN_ONE;
                                end
                                o_res.valid = 1'b1;
                                o_res.kind  = OK_SEQ;
                                o_res.data  = i_byte;
                            end else if (!w_class.is_eol) begin
                                n_bad = 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_mode = r_mode;
                    end
                endcase
            end
        end
    end

    assign o_length = r_count;
    assign o_bad    = n_bad;

    // The letter count is only non-zero inside sequence lines
    a_count_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_mode == M_SEQ))
        else $error("letter count non-zero outside sequence mode");

    // Error mode is never left without reset
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_ERROR) |=> (r_mode == M_ERROR))
        else $error("format error mode left");

    // Sticky flag never clears
    a_bad_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bad |=> r_bad)
        else $error("invalid-byte flag cleared");

endmodule : frp_ctrl
`default_nettype wire

>>> src/frp_stats.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frp_stats
// Record index, length verdict and running discard statistics, updated when
// a record closes.
// ----------------------------------------------------------------------------
module frp_stats #(
    parameter int unsigned LENGTH_BITS = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_close,
    input  wire logic [LENGTH_BITS-1:0] i_length,
    input  wire logic [23:0]            i_min_length,
    input  wire logic [23:0]            i_max_length,
    output frp_pkg::t_stats_view        o_view
);
    import frp_pkg::*;

    logic [31:0]            r_records, n_records;
    logic [31:0]            r_short_total, n_short_total;
    logic [31:0]            r_long_total, n_long_total;
    logic [LENGTH_BITS-1:0] r_shortest, n_shortest;
    logic [LENGTH_BITS-1:0] r_longest, n_longest;
    logic [31:0]            w_len;
    logic                   w_too_short;
    logic                   w_too_long;
    t_verdict               w_verdict;

    // Length checks against the limits (zero max means unbounded)
    assign w_len       = 32'(i_length);
    assign w_too_short = w_len < 32'(i_min_length);
    assign w_too_long  = (i_max_length != '0) && (w_len > 32'(i_max_length));

    always_comb begin
        n_records     = r_records;
        n_short_total = r_short_total;
        n_long_total  = r_long_total;
        n_shortest    = r_shortest;
        n_longest     = r_longest;
        w_verdict     = V_KEPT;
        if (i_close) begin
            n_records = r_records + 32'd1;
            if (w_too_short) begin
                w_verdict = V_SHORT;
                if (r_short_total != '1) begin
                    n_short_total = r_short_total + 32'd1;
                end
                if ((r_shortest == '0) || (i_length < r_shortest)) begin
                    n_shortest = i_length;
                end
            end else if (w_too_long) begin
                w_verdict = V_LONG;
                if (r_long_total != '1) begin
                    n_long_total = r_long_total + 32'd1;
                end
                if ((r_longest == '0) || (i_length > r_longest)) begin
                    n_longest = i_length;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_records     <= '0;
            r_short_total <= '0;
            r_long_total  <= '0;
            r_shortest    <= '0;
            r_longest     <= '0;
        end else begin
            r_records     <= n_records;
            r_short_total <= n_short_total;
            r_long_total  <= n_long_total;
            r_shortest    <= n_shortest;
            r_longest     <= n_longest;
        end
    end

    // Index of the closing record, then the updated running values
    assign o_view.verdict     = w_verdict;
    assign o_view.index       = r_records;
    assign o_view.short_count = n_short_total;
    assign o_view.long_count  = n_long_total;
    assign o_view.shortest    = 24'(n_shortest);
    assign o_view.longest     = 24'(n_longest);

    a_short_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_short_total >= $past(r_short_total)))
        else $error("too-short total went down");

    a_shortest_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_shortest != '0) |-> (r_short_total != '0))
        else $error("shortest length set with no short record");

    a_longest_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_longest != '0) |-> (r_long_total != '0))
        else $error("longest length set with no long record");

endmodule : frp_stats
`default_nettype wire

>>> src/fasta_record_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fasta_record_parser
// Parses a FASTA byte stream into label characters, sequence letters and
// record-end reports with length verdicts and discard statistics.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake     Carries
//  i_in      in         valid/ready   kind, data_byte
//  o_out     out        valid/ready   result fields
//  i_cfg_*   in         write enable  register index, data
//
//  One item per cycle while o_out is not stalled; every item is decided in the
//  cycle it is accepted and its result, if any, appears in the output register in the next cycle.
//  i_in.ready is high whenever the output register is empty or being taken.
//  A stall on o_out holds the result and stops input only while it lasts.
//  Synchronous active-low reset clears mode, counters and configuration.
// ----------------------------------------------------------------------------
module fasta_record_parser #(
    parameter int unsigned LENGTH_BITS = 24
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    frp_in_if.sink                                    i_in,
    frp_out_if.source                                 o_out,
    input  wire logic                                 i_cfg_we,
    input  wire logic [frp_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  wire logic [frp_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    import frp_pkg::*;

    logic                   r_allow_gaps;
    logic                   r_truncate;
    logic [23:0]            r_min_length;
    logic [23:0]            r_max_length;

    logic                   w_ready;
    logic                   w_fire;
    t_ctrl_res              w_res;
    logic [LENGTH_BITS-1:0] w_length;
    logic                   w_bad;
    t_stats_view            w_view;

    logic                   r_out_valid;
    t_out_kind              r_kind;
    logic [7:0]             r_byte;
    logic [23:0]            r_length;
    t_verdict               r_verdict;
    logic [31:0]            r_index;
    logic                   r_bad;
    logic [31:0]            r_short_count;
    logic [31:0]            r_long_count;
    logic [23:0]            r_shortest;
    logic [23:0]            r_longest;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow_gaps <= 1'b0;
            r_truncate   <= 1'b0;
            r_min_length <= '0;
            r_max_length <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ALLOW_GAPS: r_allow_gaps <= i_cfg_data[0];
                CFG_TRUNCATE:   r_truncate   <= i_cfg_data[0];
                CFG_MIN_LENGTH: r_min_length <= i_cfg_data[23:0];
                CFG_MAX_LENGTH: r_max_length <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Input handshake
    assign w_ready    = !r_out_valid || o_out.ready;
    assign w_fire     = i_in.valid && w_ready;
    assign i_in.ready = w_ready;

    frp_ctrl #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_kind       (i_in.kind),
        .i_byte       (i_in.data_byte),
        .i_allow_gaps (r_allow_gaps),
        .i_truncate   (r_truncate),
        .o_res        (w_res),
        .o_length     (w_length),
        .o_bad        (w_bad)
    );

    frp_stats #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_stats (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_close      (w_res.close),
        .i_length     (w_length),
        .i_min_length (r_min_length),
        .i_max_length (r_max_length),
        .o_view       (w_view)
    );

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload; record fields only for a record end
    always_ff @(posedge i_clk) begin
        if (w_fire && w_res.valid) begin
            r_kind        <= w_res.kind;
            r_byte        <= w_res.data;
            r_length      <= w_res.close ? 24'(w_length) : '0;
            r_verdict     <= w_res.close ? w_view.verdict : V_KEPT;
            r_index       <= w_res.close ? w_view.index : '0;
            r_bad         <= w_bad;
            r_short_count <= w_view.short_count;
            r_long_count  <= w_view.long_count;
            r_shortest    <= w_view.shortest;
            r_longest     <= w_view.longest;
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.out_kind           = r_kind;
    assign o_out.out_byte           = r_byte;
    assign o_out.record_length      = r_length;
    assign o_out.verdict            = r_verdict;
    assign o_out.record_index       = r_index;
    assign o_out.bad_byte_seen      = r_bad;
    assign o_out.short_count        = r_short_count;
    assign o_out.long_count         = r_long_count;
    assign o_out.shortest_discarded = r_shortest;
    assign o_out.longest_discarded  = r_longest;

    a_verdict_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_verdict != V_KEPT)) |-> (r_kind == OK_END))
        else $error("discard verdict on a result that is not a record end");

    a_byte_only_chars: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && ((r_kind == OK_END) || (r_kind == OK_ERROR))) |-> (r_byte == '0))
        else $error("character on a record end or error result");

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !w_fire)
        else $error("item accepted while a result is stalled");

endmodule : fasta_record_parser
`default_nettype wire

>>> test/frp_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frp_result_checker
// Watches the byte and result channels of the FASTA record parser, predicts
// every result from the accepted bytes and the register writes, and compares
// each accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module frp_result_checker #(
    parameter int unsigned LENGTH_BITS = 24
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    frp_in_if                                         i_in,
    frp_out_if                                        i_out,
    input  wire logic                                 i_cfg_we,
    input  wire logic [frp_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  wire logic [frp_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    output int                                        o_fail_count,
    output int                                        o_pending
);
    import frp_pkg::*;

    localparam logic [23:0] LEN_CAP = 24'((64'd1 << LENGTH_BITS) - 64'd1);

    typedef struct packed {
        t_out_kind   kind;
        logic [7:0]  ch;
        logic [23:0] len;
        t_verdict    verdict;
        logic [31:0] index;
        logic        bad;
        logic [31:0] n_short;
        logic [31:0] n_long;
        logic [23:0] shortest;
        logic [23:0] longest;
    } t_parse_result;

    // Register copies
    logic        keep_gaps;
    logic        cut_labels;
    logic [23:0] min_len;
    logic [23:0] max_len;

    // Parser state copy
    t_mode       mode;
    logic        prev_eol;
    logic [23:0] letters;
    logic [31:0] rec_seen;
    logic [31:0] short_tot;
    logic [31:0] long_tot;
    logic [23:0] shortest_len;
    logic [23:0] longest_len;
    logic        bad_seen;

    t_parse_result awaited_results[$];
    t_parse_result oldest;
    int            fail_total = 0;
    int            pending_count = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_count;

    function automatic bit is_eol_byte(logic [7:0] b);
        return b == C_LF || b == C_CR;
    endfunction

    function automatic bit is_letter_byte(logic [7:0] b);
        return (b >= C_UC_A && b <= C_UC_Z) || (b >= C_LC_A && b <= C_LC_Z);
    endfunction

    function automatic bit is_gap_byte(logic [7:0] b);
        return b == C_DASH || b == C_DOT;
    endfunction

    function automatic void clear_parser();
        keep_gaps    = 1'b0;
        cut_labels   = 1'b0;
        min_len      = '0;
        max_len      = '0;
        mode         = M_FIRST;
        prev_eol     = 1'b1;
        letters      = '0;
        rec_seen     = '0;
        short_tot    = '0;
        long_tot     = '0;
        shortest_len = '0;
        longest_len  = '0;
        bad_seen     = 1'b0;
    endfunction

    // Every result carries the running statistics as they stand after the item
    function automatic void queue_result(t_out_kind k, logic [7:0] ch, logic [23:0] len,
                                         t_verdict v, logic [31:0] idx);
        t_parse_result r;
        r.kind     = k;
        r.ch       = ch;
        r.len      = len;
        r.verdict  = v;
        r.index    = idx;
        r.bad      = bad_seen;
        r.n_short  = short_tot;
        r.n_long   = long_tot;
        r.shortest = shortest_len;
        r.longest  = longest_len;
        awaited_results.push_back(r);
    endfunction

    // Judge the open record against the length window and report it
    function automatic void close_record();
        logic [23:0] len;
        t_verdict    v;
        len = letters;
        v   = V_KEPT;
        if (len < min_len) begin
            v = V_SHORT;
            if (short_tot != '1) short_tot++;
            if (shortest_len == '0 || len < shortest_len) shortest_len = len;
        end else if (max_len != '0 && len > max_len) begin
            v = V_LONG;
            if (long_tot != '1) long_tot++;
            if (longest_len == '0 || len > longest_len) longest_len = len;
        end
        queue_result(OK_END, 8'h00, len, v, rec_seen);
        rec_seen++;
        letters = '0;
    endfunction

    // Next-state and result prediction for one accepted item
    function automatic void parse_item(logic k, logic [7:0] b);
        logic [7:0] ch;
        ch = b;
        if (mode == M_ERROR) begin
            queue_result(OK_ERROR, 8'h00, '0, V_KEPT, '0);
            return;
        end
        if (k == IN_END) begin
            if (mode == M_FIRST) return;
            close_record();
            mode     = M_FIRST;
            prev_eol = 1'b1;
            return;
        end
        case (mode)
            M_FIRST: begin
                if (b == C_GT) begin
                    mode    = M_LABEL;
                    letters = '0;
                end else begin
                    mode = M_ERROR;
                    queue_result(OK_ERROR, 8'h00, '0, V_KEPT, '0);
                end
            end
            M_LABEL: begin
                if (is_eol_byte(b)) begin
                    mode     = M_SEQ;
                    prev_eol = 1'b1;
                end else if (cut_labels &&
                             (b == C_SPACE || b == C_TAB || b == C_VT || b == C_FF)) begin
                    mode = M_SKIP;
                end else begin
                    if (!cut_labels && b == C_TAB) ch = C_SPACE;
                    queue_result(OK_LABEL, ch, '0, V_KEPT, '0);
                end
            end
            M_SKIP: begin
                if (is_eol_byte(b)) begin
                    mode     = M_SEQ;
                    prev_eol = 1'b1;
                end
            end
            default: begin
                if (b == C_GT && prev_eol) begin
                    close_record();
                    mode     = M_LABEL;
                    prev_eol = 1'b0;
                end else begin
                    prev_eol = is_eol_byte(b);
                    if (is_letter_byte(b) || (is_gap_byte(b) && keep_gaps)) begin
                        if (letters < LEN_CAP) letters++;
                        queue_result(OK_SEQ, b, '0, V_KEPT, '0);
                    end else if (!is_eol_byte(b)) begin
                        bad_seen = 1'b1;
                    end
                    mode = M_SEQ;
                end
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_total++;
        end
    endfunction

    // Register writes, then results out, then bytes in
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            awaited_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ALLOW_GAPS: keep_gaps  = i_cfg_data[0];
                    CFG_TRUNCATE:   cut_labels = i_cfg_data[0];
                    CFG_MIN_LENGTH: min_len    = i_cfg_data[23:0];
                    CFG_MAX_LENGTH: max_len    = i_cfg_data[23:0];
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result with none expected: out_kind %0d, out_byte %0h",
                           i_out.out_kind, i_out.out_byte);
                    fail_total++;
                end else begin
                    oldest = awaited_results.pop_front();
                    check_field("out_kind", 32'(oldest.kind), 32'(i_out.out_kind));
                    check_field("out_byte", 32'(oldest.ch), 32'(i_out.out_byte));
                    check_field("record_length", 32'(oldest.len), 32'(i_out.record_length));
                    check_field("verdict", 32'(oldest.verdict), 32'(i_out.verdict));
                    check_field("record_index", oldest.index, i_out.record_index);
                    check_field("bad_byte_seen", 32'(oldest.bad), 32'(i_out.bad_byte_seen));
                    check_field("short_count", oldest.n_short, i_out.short_count);
                    check_field("long_count", oldest.n_long, i_out.long_count);
                    check_field("shortest_discarded", 32'(oldest.shortest),
                                32'(i_out.shortest_discarded));
                    check_field("longest_discarded", 32'(oldest.longest),
                                32'(i_out.longest_discarded));
                end
            end
            if (i_in.valid && i_in.ready) parse_item(i_in.kind, i_in.data_byte);
        end
        pending_count = awaited_results.size();
    end

endmodule : frp_result_checker

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the FASTA record parser with directed corner cases and random FASTA
// files under several register settings and idle patterns; the result
// checker beside the block predicts and compares, this module gives verdict.
// ----------------------------------------------------------------------------
module testbench;
    import frp_pkg::*;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    int fail_count;
    int pending;
    int sent_items = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int phase_start;

    frp_in_if  in_ch ();
    frp_out_if out_ch ();

    fasta_record_parser dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    frp_result_checker result_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 50 MHz clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result side: random stalls, or a long hold-off when one is requested
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // Offer one item; returns at the falling edge after it was taken
    task automatic send_item(input logic k, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= k;
        in_ch.data_byte <= b;
        do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
        @(negedge clk);
        sent_items++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(IN_DATA, b);
    endtask

    // Stop offering and wait until every predicted result has been taken
    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    // One-bit registers get random upper bits, which the block must ignore
    task automatic apply_settings(input logic gaps, input logic cut,
                                  input logic [23:0] lo, input logic [23:0] hi);
        settle();
        write_reg(CFG_ALLOW_GAPS, {23'($urandom), gaps});
        write_reg(CFG_TRUNCATE, {23'($urandom), cut});
        write_reg(CFG_MIN_LENGTH, lo);
        write_reg(CFG_MAX_LENGTH, hi);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] label_byte();
        int r;
        r = $urandom_range(99);
        if (r < 8) begin
            case ($urandom_range(3))
                0: return C_SPACE;
                1: return C_TAB;
                2: return C_VT;
                default: return C_FF;
            endcase
        end
        if (r < 14) return 8'($urandom);
        return 8'($urandom_range(126, 33));
    endfunction

    function automatic logic [7:0] seq_byte();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 8'($urandom_range(25)) + ($urandom_range(1) ? C_UC_A : C_LC_A);
        if (r < 80) return $urandom_range(1) ? C_DASH : C_DOT;
        if (r < 86) return C_GT;
        return 8'($urandom);
    endfunction

    task automatic send_line_end();
        case ($urandom_range(2))
            0: send_byte(C_LF);
            1: send_byte(C_CR);
            default: begin
                send_byte(C_CR);
                send_byte(C_LF);
            end
        endcase
    endtask

    // Header line and a few sequence lines; a bare header when lines are off
    task automatic send_record(input bit with_lines);
        int n;
        int lines;
        send_byte(C_GT);
        n = $urandom_range(8);
        repeat (n) send_byte(label_byte());
        if (!with_lines) return;
        send_line_end();
        lines = $urandom_range(3);
        repeat (lines) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
            repeat (n) send_byte(seq_byte());
            send_line_end();
        end
    endtask

    // A whole file: records, sometimes an unfinished header, then end of input
    task automatic send_file();
        int nrec;
        nrec = 1 + $urandom_range(3);
        repeat (nrec) send_record(1'b1);
        if ($urandom_range(9) == 0) send_record(1'b0);
        send_item(IN_END, 8'($urandom));
        if ($urandom_range(9) == 0) send_item(IN_END, 8'($urandom));
    endtask

    initial begin
        logic [23:0] lo;
        logic [23:0] hi;
        in_ch.valid     = 1'b0;
        in_ch.kind      = IN_DATA;
        in_ch.data_byte = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty input, label extremes, tabs, CR/LF, gaps dropped,
        // misplaced header mark, unfinished header
        send_item(IN_END, 8'hFF);
        send_byte(C_GT);
        send_byte(8'hFF);
        send_byte(C_TAB);
        send_byte(8'h00);
        send_byte(C_CR);
        send_byte(C_LF);
        send_byte(C_UC_A);
        send_byte(C_LC_Z);
        send_byte(C_DASH);
        send_byte(C_GT);
        send_byte(8'h00);
        send_byte(C_LF);
        send_byte(C_GT);
        send_item(IN_END, 8'h00);

        // Directed: truncated labels, gaps kept, short and long records
        apply_settings(1'b1, 1'b1, 24'd1, 24'd2);
        send_byte(C_GT);
        send_byte(C_LC_A);
        send_byte(C_SPACE);
        send_byte(C_UC_Z);
        send_byte(C_LF);
        send_byte(C_DOT);
        send_byte(C_DASH);
        send_byte(C_UC_Z);
        send_byte(C_LF);
        send_byte(C_GT);
        send_byte(C_VT);
        send_byte(C_FF);
        send_item(IN_END, 8'h00);

        // Random files over several settings and idle patterns
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: apply_settings(1'b0, 1'b0, 24'd0, 24'd0);
                1: apply_settings(1'b1, 1'b1, 24'hFFFFFF, 24'hFFFFFF);
                2: apply_settings(1'b0, 1'b1, 24'd0, 24'hFFFFFF);
                3: apply_settings(1'b1, 1'b0, 24'd0, 24'd1);
                default: begin
                    lo = 24'($urandom_range(12));
                    hi = $urandom_range(2) == 0 ? 24'd0 : lo + 24'($urandom_range(20));
                    apply_settings(1'($urandom), 1'($urandom), lo, hi);
                end
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 70; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 70; end
                default: begin send_idle_pct = 11; stall_pct = 11; end
            endcase
            // long receiver hold-off while bytes keep coming
            if (p == 4) hold_left = 300;
            phase_start = sent_items;
            while (sent_items - phase_start < 60) send_file();
        end

        // Bad first byte: sticky format error for every item after it
        send_byte(C_UC_A);
        repeat (6) send_item(1'($urandom), 8'($urandom));

        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule : testbench

>>> fasta_record_parser.f
src/frp_pkg.sv
src/frp_in_if.sv
src/frp_out_if.sv
src/frp_classify.sv
src/frp_ctrl.sv
src/frp_stats.sv
src/fasta_record_parser.sv
test/frp_result_checker.sv
test/testbench.sv
